>>> hw/rtl/gmr_pkg.sv
// shared constants, types and helper functions for the grid mixed-radix scanner
package gmr_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int COORD_BITS  = 12;
    localparam int NUM_IO_DIMS = 4;

    localparam int ACTION_W    = 3;
    localparam int COORD_IN_W  = 16;
    localparam int COORD_OUT_W = 12;
    localparam int IDX_W       = 48;
    localparam int HALF_W      = IDX_W / 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int DIMS_REG_W  = 3;

    localparam int SIZE_W      = COORD_BITS + 1;
    localparam int SIZE_TOP    = 1 << COORD_BITS;

    localparam int DIV_BITS    = 4;
    localparam int DIV_CYCLES  = COORD_IN_W / DIV_BITS;
    localparam int ACT_CYCLES  = ((MAX_DIMS > DIV_CYCLES) ? MAX_DIMS : DIV_CYCLES) + 1;
    localparam int IDX_CYCLES  = 2 * MAX_DIMS;
    localparam int CNT_MAX     = (ACT_CYCLES > IDX_CYCLES) ? ACT_CYCLES : IDX_CYCLES;
    localparam int CNT_W       = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
    localparam int CELL_IDX_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef enum logic [ACTION_W-1:0] {
        OP_FWD    = 3'd0,
        OP_BWD    = 3'd1,
        OP_SET    = 3'd2,
        OP_REWIND = 3'd3,
        OP_QUERY  = 3'd4
    } t_action;

    localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_BASE = 3'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACT,
        ST_IDX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit_set;
        logic rewind;
        logic dir_bwd;
    } t_cell_ctl;

    // clamp a size register to 1 .. 2^COORD_BITS
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (int'(s) > SIZE_TOP) begin
            r = SIZE_W'(SIZE_TOP);
        end else begin
            r = SIZE_W'(s);
        end
        return r;
    endfunction

    // index of the fastest used dimension
    function automatic logic [CELL_IDX_W-1:0] last_dim(input logic [DIMS_REG_W-1:0] d);
        logic [CELL_IDX_W-1:0] r;
        if (d == '0) begin
            r = '0;
        end else if (int'(d) > MAX_DIMS) begin
            r = CELL_IDX_W'(MAX_DIMS - 1);
        end else begin
            r = CELL_IDX_W'(int'(d) - 1);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/gmr_if.sv
// handshake channel interfaces: input items, results and configuration writes
interface gmr_in_if;
    import gmr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [COORD_IN_W-1:0] coord_in_0;
    logic [COORD_IN_W-1:0] coord_in_1;
    logic [COORD_IN_W-1:0] coord_in_2;
    logic [COORD_IN_W-1:0] coord_in_3;

    modport source (output valid, action, coord_in_0, coord_in_1, coord_in_2, coord_in_3,
                    input ready);
    modport sink   (input valid, action, coord_in_0, coord_in_1, coord_in_2, coord_in_3,
                    output ready);
endinterface

interface gmr_out_if;
    import gmr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [IDX_W-1:0]       linear_index;
    logic                   done_flag;
    logic [COORD_OUT_W-1:0] coord_out_0;
    logic [COORD_OUT_W-1:0] coord_out_1;
    logic [COORD_OUT_W-1:0] coord_out_2;
    logic [COORD_OUT_W-1:0] coord_out_3;

    modport source (output valid, linear_index, done_flag,
                    coord_out_0, coord_out_1, coord_out_2, coord_out_3,
                    input ready);
    modport sink   (input valid, linear_index, done_flag,
                    coord_out_0, coord_out_1, coord_out_2, coord_out_3,
                    output ready);
endinterface

interface gmr_cfg_if;
    import gmr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/gmr_cell.sv
// one odometer digit: coordinate, size, carry token, remainder unit and horner stage
module gmr_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gmr_pkg::t_cell_ctl               i_ctl,
    input  logic                             i_used,
    input  logic                             i_carry_in,
    input  logic [gmr_pkg::COORD_IN_W-1:0]   i_coord_in,
    input  logic                             i_size_we,
    input  logic [gmr_pkg::CFG_DATA_W-1:0]   i_size_data,
    input  logic [gmr_pkg::IDX_W-1:0]        i_acc,
    output logic [gmr_pkg::COORD_BITS-1:0]   o_coord,
    output logic                             o_carry,
    output logic [gmr_pkg::IDX_W-1:0]        o_acc
);
    import gmr_pkg::*;

    logic [CFG_DATA_W-1:0]      r_size;
    logic [COORD_BITS-1:0]      r_coord;
    logic [COORD_BITS-1:0]      n_coord;
    logic                       r_carry;
    logic                       n_carry;
    logic [COORD_IN_W-1:0]      r_div;
    logic [SIZE_W-1:0]          r_rem;
    logic [SIZE_W-1:0]          n_rem;
    logic [HALF_W+SIZE_W-1:0]   r_pl;
    logic [HALF_W+SIZE_W-1:0]   n_pl;
    logic [IDX_W-HALF_W-1:0]    r_ph;
    logic [IDX_W-HALF_W+SIZE_W-1:0] w_ph_full;
    logic [IDX_W-1:0]           r_acc;
    logic [SIZE_W-1:0]          w_eff;
    logic [SIZE_W-1:0]          w_next;

    assign w_eff  = eff_size(r_size);
    assign w_next = SIZE_W'(r_coord) + SIZE_W'(1);

    // coordinate update and carry/borrow token
    always_comb begin
        n_coord = r_coord;
        n_carry = 1'b0;
        if (i_ctl.rewind) begin
            n_coord = '0;
        end else if (i_ctl.commit_set) begin
            n_coord = i_used ? r_rem[COORD_BITS-1:0] : '0;
        end else if (i_carry_in) begin
            if (i_ctl.dir_bwd) begin
                if (r_coord != '0) begin
                    n_coord = r_coord - COORD_BITS'(1);
                end else begin
                    n_coord = COORD_BITS'(w_eff - SIZE_W'(1));
                    n_carry = 1'b1;
                end
            end else begin
                if (w_next < w_eff) begin
                    n_coord = w_next[COORD_BITS-1:0];
                end else begin
                    n_coord = '0;
                    n_carry = 1'b1;
                end
            end
        end
    end

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb begin
        logic [SIZE_W-1:0] t;
        t = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            t = {t[SIZE_W-2:0], r_div[COORD_IN_W-1-k]};
            if (t >= w_eff) begin
                t = t - w_eff;
            end
        end
        n_rem = t;
    end

    // horner step split in two half-width partial products
    assign n_pl      = i_acc[HALF_W-1:0] * w_eff;
    assign w_ph_full = i_acc[IDX_W-1:HALF_W] * w_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= CFG_DATA_W'(1);
            r_coord <= '0;
            r_carry <= 1'b0;
        end else begin
            if (i_size_we) begin
                r_size <= i_size_data;
            end
            r_coord <= n_coord;
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_div <= i_coord_in;
            r_rem <= '0;
        end else if (i_ctl.div_step) begin
            r_div <= r_div << DIV_BITS;
            r_rem <= n_rem;
        end
        r_pl  <= n_pl;
        r_ph  <= w_ph_full[IDX_W-HALF_W-1:0];
        r_acc <= IDX_W'(r_pl) + {r_ph, HALF_W'(0)} + IDX_W'(r_coord);
    end

    assign o_coord = r_coord;
    assign o_carry = r_carry;
    assign o_acc   = r_acc;

endmodule

>>> hw/rtl/grid_mixed_radix_scanner.sv
// top level of the mixed-radix grid odometer: sequencer, config registers, cell row, result register
//
//  channel   port    dir  payload
//  -------   -----   ---  ----------------------------------------------------
//  item      i_in    in   action, coord_in_0..3
//  result    o_res   out  linear_index, done_flag, coord_out_0..3
//  config    i_cfg   in   index (0 dims_in_use, 1..4 size_dim_0..3), data
//
//  a transaction runs through accept, the action phase (the carry token moves one cell
//  per cycle and each remainder unit takes 4 dividend bits per cycle), the index phase
//  (two pipeline stages per cell in the horner chain) and the result load.
//  a new item is taken while the previous result still waits in the output register.
//  reset clears coordinates, the wrapped flag and sets dims_in_use and all sizes to 1.
//  a stalled result holds the sequencer in its last state until the register frees.
module grid_mixed_radix_scanner (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gmr_in_if.sink    i_in,
    gmr_out_if.source o_res,
    gmr_cfg_if.sink   i_cfg
);
    import gmr_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;
    logic [ACTION_W-1:0]     r_action;
    logic [DIMS_REG_W-1:0]   r_dims;
    logic                    r_wrapped;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_done;
    logic [COORD_OUT_W-1:0]  r_out_coord [NUM_IO_DIMS];

    t_cell_ctl               w_ctl;
    logic                    w_start;
    logic                    w_load_out;
    logic                    w_in_acc;
    logic                    w_cfg_acc;
    logic [CELL_IDX_W-1:0]   w_last;
    logic [MAX_DIMS-1:0]     w_used;
    logic [MAX_DIMS-1:0]     w_carry;
    logic [MAX_DIMS-1:0]     w_carry_in;
    logic [MAX_DIMS-1:0]     w_size_we;
    logic [COORD_BITS-1:0]   w_coord   [MAX_DIMS];
    logic [IDX_W-1:0]        w_acc     [MAX_DIMS];
    logic [IDX_W-1:0]        w_acc_in  [MAX_DIMS];
    logic [COORD_IN_W-1:0]   w_cin     [MAX_DIMS];
    logic [COORD_IN_W-1:0]   w_io_cin  [NUM_IO_DIMS];
    logic [COORD_OUT_W-1:0]  w_cout    [NUM_IO_DIMS];

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_last     = last_dim(r_dims);

    assign w_io_cin[0] = i_in.coord_in_0;
    assign w_io_cin[1] = i_in.coord_in_1;
    assign w_io_cin[2] = i_in.coord_in_2;
    assign w_io_cin[3] = i_in.coord_in_3;

    genvar g;
    generate
        for (g = 0; g < MAX_DIMS; g++) begin : g_cell
            assign w_used[g] = (CELL_IDX_W'(g) <= w_last);

            if (g < NUM_IO_DIMS) begin : g_io
                assign w_cin[g]     = w_io_cin[g];
                assign w_size_we[g] = w_cfg_acc &&
                                      (int'(i_cfg.index) == int'(REG_SIZE_BASE) + g);
            end else begin : g_noio
                assign w_cin[g]     = '0;
                assign w_size_we[g] = 1'b0;
            end

            // the token enters at the fastest used cell and walks toward cell zero
            if (g < MAX_DIMS - 1) begin : g_mid
                assign w_carry_in[g] = (w_start && (w_last == CELL_IDX_W'(g))) ||
                                       (w_carry[g+1] && w_used[g]);
            end else begin : g_end
                assign w_carry_in[g] = w_start && (w_last == CELL_IDX_W'(g));
            end

            if (g == 0) begin : g_first
                assign w_acc_in[g] = '0;
            end else begin : g_rest
                assign w_acc_in[g] = w_acc[g-1];
            end

            gmr_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_used      (w_used[g]),
                .i_carry_in  (w_carry_in[g]),
                .i_coord_in  (w_cin[g]),
                .i_size_we   (w_size_we[g]),
                .i_size_data (i_cfg.data),
                .i_acc       (w_acc_in[g]),
                .o_coord     (w_coord[g]),
                .o_carry     (w_carry[g]),
                .o_acc       (w_acc[g])
            );
        end

        for (g = 0; g < NUM_IO_DIMS; g++) begin : g_cout
            if (g < MAX_DIMS) begin : g_have
                assign w_cout[g] = w_used[g] ? COORD_OUT_W'(w_coord[g]) : '0;
            end else begin : g_none
                assign w_cout[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        w_ctl          = '0;
        w_ctl.load     = w_in_acc;
        w_ctl.dir_bwd  = (r_action == OP_BWD);
        w_start        = 1'b0;
        w_load_out     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_ACT;
                    n_cnt   = '0;
                end
            end
            ST_ACT: begin
                w_ctl.div_step   = (r_cnt < CNT_W'(DIV_CYCLES));
                w_ctl.commit_set = (r_action == OP_SET) && (r_cnt == CNT_W'(DIV_CYCLES));
                w_ctl.rewind     = (r_action == OP_REWIND) && (r_cnt == '0);
                w_start          = ((r_action == OP_FWD) || (r_action == OP_BWD)) &&
                                   (r_cnt == '0);
                if (r_cnt == CNT_W'(ACT_CYCLES - 1)) begin
                    n_state = ST_IDX;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_IDX: begin
                if (r_cnt == CNT_W'(IDX_CYCLES - 1)) begin
                    n_state = ST_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_dims      <= DIMS_REG_W'(1);
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_cfg_acc && (i_cfg.index == REG_DIMS)) begin
                r_dims <= i_cfg.data[DIMS_REG_W-1:0];
            end
            // stepping or a rewind clears the flag; a token leaving cell zero means a full wrap
            if (w_in_acc && ((i_in.action == OP_FWD) || (i_in.action == OP_BWD))) begin
                r_wrapped <= 1'b0;
            end else if (w_ctl.rewind) begin
                r_wrapped <= 1'b0;
            end else if (w_carry[0]) begin
                r_wrapped <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_action <= i_in.action;
        end
        if (w_load_out) begin
            r_out_idx  <= w_acc[w_last];
            r_out_done <= r_wrapped;
            for (int d = 0; d < NUM_IO_DIMS; d++) begin
                r_out_coord[d] <= w_cout[d];
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.linear_index = r_out_idx;
    assign o_res.done_flag    = r_out_done;
    assign o_res.coord_out_0  = r_out_coord[0];
    assign o_res.coord_out_1  = r_out_coord[1];
    assign o_res.coord_out_2  = r_out_coord[2];
    assign o_res.coord_out_3  = r_out_coord[3];

    // only one carry token in the row at a time
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_carry))
        else $error("more than one carry token in the cell row");

    // tokens live only while the action runs
    a_token_in_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_carry != '0) |-> (r_state == ST_ACT))
        else $error("carry token outside the action phase");

    // a finished result waits while the output register is still held
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_res.ready) |=> (r_state == ST_DONE))
        else $error("result overwrote an untaken output");

endmodule
